// File: hw/rtl/saced_pkg.sv
// Package: types, constants and axis processing for the six-axis event decoder.
`default_nettype none

package saced_pkg;

  localparam int BUTTON_COUNT_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int AXIS_COUNT       = 6;
  localparam int AXIS_W           = 3;
  localparam int BTN_IDX_W        = 6;
  localparam int VISIBLE_BUTTONS  = 32;

  localparam int AX_SHIFT = 20;
  localparam int AX_RECIP = ((1 << AX_SHIFT) + AXIS_COUNT - 1) / AXIS_COUNT;

  localparam logic [7:0]  DEADZONE_RST   = 8'd5;
  localparam logic [14:0] FULL_SCALE_RST = 15'd400;
  localparam logic [15:0] IDLE_TICKS_RST = 16'd50;

  localparam logic [1:0] CFG_DEADZONE   = 2'd0;
  localparam logic [1:0] CFG_FULL_SCALE = 2'd1;
  localparam logic [1:0] CFG_IDLE_TICKS = 2'd2;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_HID   = 2'd1;
  localparam logic [1:0] REQ_IDLE  = 2'd2;

  localparam logic [15:0] EV_SYNC = 16'd0;
  localparam logic [15:0] EV_KEY  = 16'd1;
  localparam logic [15:0] EV_REL  = 16'd2;
  localparam logic [15:0] EV_ABS  = 16'd3;

  localparam logic [7:0] HID_TRANS = 8'd1;
  localparam logic [7:0] HID_ROT   = 8'd2;
  localparam logic [7:0] HID_BTN   = 8'd3;

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SYNC,
    OP_KEY,
    OP_REL,
    OP_ABS,
    OP_EV_OTHER,
    OP_HID_AXES,
    OP_HID_BTN,
    OP_IDLE
  } op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
    logic [7:0]         hid_kind;
    logic signed [15:0] hid_word0;
    logic signed [15:0] hid_word1;
    logic signed [15:0] hid_word2;
  } in_t;

  typedef struct packed {
    logic signed [15:0] trans_x;
    logic signed [15:0] trans_y;
    logic signed [15:0] trans_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic [31:0]        pressed_buttons;
    logic               absolute_device;
  } out_t;

  typedef struct packed {
    logic [7:0]  deadzone;
    logic [14:0] full_scale;
    logic [15:0] idle_ticks;
  } cfg_t;

  typedef struct packed {
    op_t                  op;
    logic [AXIS_W-1:0]    axis;
    logic                 hid_rot;
    logic [BTN_IDX_W-1:0] btn;
    logic [31:0]          value;
    logic [2:0][15:0]     words;
  } cmd_t;

  function automatic logic signed [15:0] commit_axis(
    input logic [31:0] v,
    input logic [7:0]  dz,
    input logic [14:0] fs
  );
    logic signed [32:0] v33;
    logic signed [32:0] mag;
    logic signed [32:0] dzx;
    logic signed [32:0] fsx;
    logic signed [32:0] sh;
    logic signed [32:0] res;
    v33 = {v[31], v};
    mag = v[31] ? -v33 : v33;
    dzx = {25'd0, dz};
    fsx = {18'd0, fs};
    if (mag < dzx) begin
      sh = '0;
    end else if (v[31]) begin
      sh = v33 + dzx;
    end else begin
      sh = v33 - dzx;
    end
    if (sh > fsx) begin
      res = fsx;
    end else if (sh < -fsx) begin
      res = -fsx;
    end else begin
      res = sh;
    end
    return res[15:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/six_axis_controller_event_decoder_unit.sv
// Top level of the six-axis controller event decoder: configuration and wiring.
// Takes one request per cycle while not stalled (event record, HID report or
// idle tick) and returns one result per request: the six processed axes, the
// low 32 button bits and the absolute-mode flag, all as they stand after that
// request. A request is accepted every cycle while results are taken; a result
// passes the input register in the front end, the queue and the result register
// in the back end, where the state update uses six deadzone and clamp units side
// by side. A queue of QUEUE_DEPTH commands lets the input keep flowing while the
// output is stalled, until the queue is full.
// Registers: 0 deadzone, 1 full scale, 2 idle timeout in ticks; write them
// only while no request is in flight.
`default_nettype none

module six_axis_controller_event_decoder_unit #(
  parameter int BUTTON_COUNT = saced_pkg::BUTTON_COUNT_DEF,
  parameter int QUEUE_DEPTH  = saced_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire saced_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output saced_pkg::out_t       out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_wdata
);

  saced_pkg::cfg_t  cfg_r;
  saced_pkg::cmd_t  push_cmd;
  saced_pkg::cmd_t  head_cmd;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone   <= saced_pkg::DEADZONE_RST;
      cfg_r.full_scale <= saced_pkg::FULL_SCALE_RST;
      cfg_r.idle_ticks <= saced_pkg::IDLE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        saced_pkg::CFG_DEADZONE:   cfg_r.deadzone   <= cfg_wdata[7:0];
        saced_pkg::CFG_FULL_SCALE: cfg_r.full_scale <= cfg_wdata[14:0];
        saced_pkg::CFG_IDLE_TICKS: cfg_r.idle_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  saced_front #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  saced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  saced_back #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/saced_front.sv
// Front end: input register, code remainders and classification into commands.
`default_nettype none

module saced_front #(
  parameter int BUTTON_COUNT = saced_pkg::BUTTON_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire saced_pkg::in_t   in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output saced_pkg::cmd_t       q_cmd
);

  localparam int BW        = $clog2(BUTTON_COUNT);
  localparam int BTN_SHIFT = 17 + BW;
  localparam logic [47:0] BTN_RECIP =
    48'(((64'd1 << BTN_SHIFT) + 64'(BUTTON_COUNT) - 64'd1) / 64'(BUTTON_COUNT));
  localparam logic [47:0] AX_RECIP_W = 48'(saced_pkg::AX_RECIP);

  logic            s1_valid_r;
  saced_pkg::in_t  s1_data_r;
  logic [15:0]     s1_q6_r;
  logic [15:0]     s1_qb_r;
  logic [47:0]     prod6;
  logic [47:0]     prodb;
  logic [15:0]     rem6;
  logic [15:0]     remb;
  logic [2:0]      ax;
  logic [2:0]      tgt;
  logic            neg;

  assign in_stall = s1_valid_r && q_full;
  assign q_push   = s1_valid_r && !q_full;

  assign prod6 = 48'(in_data.ev_code) * AX_RECIP_W;
  assign prodb = 48'(in_data.ev_code) * BTN_RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
      s1_q6_r   <= 16'(prod6 >> saced_pkg::AX_SHIFT);
      s1_qb_r   <= 16'(prodb >> BTN_SHIFT);
    end
  end

  assign rem6 = s1_data_r.ev_code - 16'(s1_q6_r * 16'(saced_pkg::AXIS_COUNT));
  assign remb = s1_data_r.ev_code - 16'(s1_qb_r * 16'(BUTTON_COUNT));
  assign ax   = rem6[2:0];

  // absolute events: swap the second and third axis of each triple, negating the value moved from the second
  always_comb begin
    tgt = ax;
    neg = 1'b0;
    unique case (ax)
      3'd1: begin
        tgt = 3'd2;
        neg = 1'b1;
      end
      3'd2: tgt = 3'd1;
      3'd4: begin
        tgt = 3'd5;
        neg = 1'b1;
      end
      3'd5: tgt = 3'd4;
      default: tgt = ax;
    endcase
  end

  always_comb begin
    q_cmd         = '0;
    q_cmd.op      = saced_pkg::OP_NONE;
    q_cmd.axis    = ax;
    q_cmd.btn     = saced_pkg::BTN_IDX_W'(remb);
    q_cmd.value   = s1_data_r.ev_value;
    q_cmd.hid_rot = (s1_data_r.hid_kind == saced_pkg::HID_ROT);
    q_cmd.words   = {s1_data_r.hid_word2, s1_data_r.hid_word1, s1_data_r.hid_word0};
    unique case (s1_data_r.req_type)
      saced_pkg::REQ_EVENT: begin
        unique case (s1_data_r.ev_type)
          saced_pkg::EV_SYNC: q_cmd.op = saced_pkg::OP_SYNC;
          saced_pkg::EV_KEY:  q_cmd.op = saced_pkg::OP_KEY;
          saced_pkg::EV_REL:  q_cmd.op = saced_pkg::OP_REL;
          saced_pkg::EV_ABS: begin
            q_cmd.op    = saced_pkg::OP_ABS;
            q_cmd.axis  = tgt;
            q_cmd.value = neg ? 32'd0 - s1_data_r.ev_value : s1_data_r.ev_value;
          end
          default: q_cmd.op = saced_pkg::OP_EV_OTHER;
        endcase
      end
      saced_pkg::REQ_HID: begin
        unique case (s1_data_r.hid_kind)
          saced_pkg::HID_TRANS, saced_pkg::HID_ROT: q_cmd.op = saced_pkg::OP_HID_AXES;
          saced_pkg::HID_BTN: q_cmd.op = saced_pkg::OP_HID_BTN;
          default:            q_cmd.op = saced_pkg::OP_NONE;
        endcase
      end
      saced_pkg::REQ_IDLE: q_cmd.op = saced_pkg::OP_IDLE;
      default:             q_cmd.op = saced_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/saced_queue.sv
// Command queue between front end and back end.
`default_nettype none

module saced_queue #(
  parameter int DEPTH = saced_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire saced_pkg::cmd_t   push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output saced_pkg::cmd_t        head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  saced_pkg::cmd_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// File: hw/rtl/saced_back.sv
// Back end: axis, button and mode state, six commit units and result register.
`default_nettype none

module saced_back #(
  parameter int BUTTON_COUNT = saced_pkg::BUTTON_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire saced_pkg::cfg_t   cfg,
  input  wire logic              q_valid,
  input  wire saced_pkg::cmd_t   q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output saced_pkg::out_t        out_data
);

  localparam int BW  = $clog2(BUTTON_COUNT);
  localparam int VIS = (BUTTON_COUNT < saced_pkg::VISIBLE_BUTTONS) ?
                       BUTTON_COUNT : saced_pkg::VISIBLE_BUTTONS;

  logic [31:0]              raw_r    [saced_pkg::AXIS_COUNT];
  logic [31:0]              raw_nxt  [saced_pkg::AXIS_COUNT];
  logic signed [15:0]       axis_r   [saced_pkg::AXIS_COUNT];
  logic signed [15:0]       axis_nxt [saced_pkg::AXIS_COUNT];
  logic [31:0]              commit_in [saced_pkg::AXIS_COUNT];
  logic signed [15:0]       commit_out [saced_pkg::AXIS_COUNT];
  logic [BUTTON_COUNT-1:0]  btn_r;
  logic [BUTTON_COUNT-1:0]  btn_nxt;
  logic                     abs_r;
  logic                     abs_nxt;
  logic                     rel_r;
  logic                     rel_nxt;
  logic [15:0]              idle_r;
  logic [15:0]              idle_nxt;
  logic                     out_valid_r;
  saced_pkg::out_t          out_data_r;
  logic [BW-1:0]            key_idx;
  logic [15:0]              idle_inc;
  logic                     ev_op;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ev_op = (q_cmd.op == saced_pkg::OP_SYNC) || (q_cmd.op == saced_pkg::OP_KEY) ||
                 (q_cmd.op == saced_pkg::OP_REL)  || (q_cmd.op == saced_pkg::OP_ABS) ||
                 (q_cmd.op == saced_pkg::OP_EV_OTHER);

  always_comb begin
    for (int k = 0; k < saced_pkg::AXIS_COUNT; k++) begin
      commit_in[k] = (q_cmd.op == saced_pkg::OP_HID_AXES) ?
                     {{16{q_cmd.words[k % 3][15]}}, q_cmd.words[k % 3]} : raw_r[k];
      commit_out[k] = saced_pkg::commit_axis(commit_in[k], cfg.deadzone, cfg.full_scale);
    end
  end

  always_comb begin
    raw_nxt  = raw_r;
    axis_nxt = axis_r;
    btn_nxt  = btn_r;
    abs_nxt  = abs_r;
    rel_nxt  = rel_r;
    idle_nxt = ev_op ? 16'd0 : idle_r;
    key_idx  = q_cmd.btn[BW-1:0];
    idle_inc = (idle_r == saced_pkg::IDLE_MAX) ? idle_r : idle_r + 16'd1;
    if (!abs_r && (key_idx <= BW'(1))) begin
      key_idx = key_idx + BW'(6);
    end
    unique case (q_cmd.op)
      saced_pkg::OP_SYNC: begin
        for (int k = 0; k < saced_pkg::AXIS_COUNT; k++) begin
          axis_nxt[k] = commit_out[k];
        end
      end
      saced_pkg::OP_KEY: btn_nxt[key_idx] = (q_cmd.value != 32'd0);
      saced_pkg::OP_REL: begin
        abs_nxt = 1'b0;
        rel_nxt = 1'b1;
        raw_nxt[q_cmd.axis] = q_cmd.value;
      end
      saced_pkg::OP_ABS: begin
        abs_nxt = 1'b1;
        rel_nxt = 1'b0;
        raw_nxt[q_cmd.axis] = q_cmd.value;
      end
      saced_pkg::OP_HID_AXES: begin
        for (int k = 0; k < saced_pkg::AXIS_COUNT; k++) begin
          if ((k >= 3) == q_cmd.hid_rot) begin
            raw_nxt[k]  = commit_in[k];
            axis_nxt[k] = commit_out[k];
          end
        end
      end
      saced_pkg::OP_HID_BTN: begin
        for (int i = 0; i < 8; i++) begin
          btn_nxt[6 + i] = q_cmd.words[0][i];
        end
      end
      saced_pkg::OP_IDLE: begin
        idle_nxt = idle_inc;
        if (rel_r && (idle_inc >= cfg.idle_ticks)) begin
          for (int k = 0; k < saced_pkg::AXIS_COUNT; k++) begin
            raw_nxt[k]  = '0;
            axis_nxt[k] = '0;
          end
          idle_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < saced_pkg::AXIS_COUNT; k++) begin
        raw_r[k]  <= '0;
        axis_r[k] <= '0;
      end
      btn_r       <= '0;
      abs_r       <= 1'b0;
      rel_r       <= 1'b0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        raw_r  <= raw_nxt;
        axis_r <= axis_nxt;
        btn_r  <= btn_nxt;
        abs_r  <= abs_nxt;
        rel_r  <= rel_nxt;
        idle_r <= idle_nxt;
      end
      out_valid_r <= q_pop || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.trans_x         <= axis_nxt[0];
      out_data_r.trans_y         <= axis_nxt[1];
      out_data_r.trans_z         <= axis_nxt[2];
      out_data_r.rot_x           <= axis_nxt[3];
      out_data_r.rot_y           <= axis_nxt[4];
      out_data_r.rot_z           <= axis_nxt[5];
      out_data_r.pressed_buttons <= 32'(btn_nxt[VIS-1:0]);
      out_data_r.absolute_device <= abs_nxt;
    end
  end

  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(abs_r && rel_r))
    else $error("absolute and relative mode both set");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(q_pop))
    else $error("result appeared without a command");

  a_event_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && ev_op) |=> (idle_r == 16'd0))
    else $error("event record left idle count set");

endmodule

`default_nettype wire

// File: tb/sv/six_axis_controller_event_decoder_unit_tb.sv
// Testbench for the six-axis event decoder: directed table, random phases, predictor check.
`timescale 1ns / 1ps

module six_axis_controller_event_decoder_unit_tb;
  import saced_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int PLAN_LEN = 25;
  localparam int PHASES = 7;

  typedef struct {
    in_t  req;
    bit   known;
    out_t want;
  } row_t;

  localparam out_t LATCHED_ONLY = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                    32'h80000080, 1'b0};
  localparam out_t FIRST_SYNC = '{16'sd400, -16'sd400, 16'sd95, 16'sd0, 16'sd0, -16'sd400,
                                  32'h80000080, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_DEADZONE;
  logic [15:0] cfg_wdata = '0;

  // predictor state and its copy of the registers
  logic [31:0] raw_latch [AXIS_COUNT];
  logic signed [15:0] axis_now [AXIS_COUNT];
  logic [31:0] btn_held;
  logic abs_flag;
  logic rel_flag;
  int idle_run;
  logic [7:0] dz_cfg;
  logic [14:0] fs_cfg;
  logic [15:0] tk_cfg;

  out_t owed_reports [$];
  out_t oldest_report;
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  int ph_dz [PHASES] = '{0, 255, 3, 0, 40, 255, 1};
  int ph_fs [PHASES] = '{32767, 1, 200, 0, 1000, 32767, 50};
  int ph_tk [PHASES] = '{1, 7, 10, 0, 20, 2, 3};
  int ph_idle [PHASES] = '{53, 0, 0, 13, 0, 53, 13};
  int ph_stall [PHASES] = '{0, 53, 53, 13, 0, 0, 13};

  row_t plan [PLAN_LEN] = '{
    '{'{REQ_UNUSED, EV_KEY, 16'd8, 32'sd1, HID_BTN, 16'sh00FF, 16'sd0, 16'sd0}, 1'b1, '0},
    '{'{REQ_EVENT, EV_KEY, 16'd0, 32'sd1, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h00000040, 1'b0}},
    '{'{REQ_EVENT, EV_KEY, 16'd33, 32'sh80000000, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h000000C0, 1'b0}},
    '{'{REQ_EVENT, EV_KEY, 16'hFFFF, 32'sd1, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h800000C0, 1'b0}},
    '{'{REQ_EVENT, EV_KEY, 16'd6, 32'sd0, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LATCHED_ONLY},
    '{'{REQ_EVENT, EV_REL, 16'd0, 32'sh7FFFFFFF, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      LATCHED_ONLY},
    '{'{REQ_EVENT, EV_REL, 16'd1, 32'sh80000000, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      LATCHED_ONLY},
    '{'{REQ_EVENT, EV_REL, 16'hFFFF, 32'sd4, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LATCHED_ONLY},
    '{'{REQ_EVENT, EV_REL, 16'd4, 32'sd5, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LATCHED_ONLY},
    '{'{REQ_EVENT, EV_REL, 16'd5, -32'sd405, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LATCHED_ONLY},
    '{'{REQ_EVENT, EV_REL, 16'd2, 32'sd100, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, LATCHED_ONLY},
    '{'{REQ_EVENT, EV_SYNC, 16'd0, 32'sd0, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, FIRST_SYNC},
    '{'{REQ_EVENT, 16'hFFFF, 16'd0, 32'sd1, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, FIRST_SYNC},
    '{'{REQ_EVENT, EV_ABS, 16'd1, 32'sh80000000, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_EVENT, EV_ABS, 16'd2, 32'sd7, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_EVENT, EV_ABS, 16'd3, -32'sd1, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_EVENT, EV_ABS, 16'd4, 32'sd1000, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_EVENT, EV_KEY, 16'd0, 32'sd1, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_EVENT, EV_SYNC, 16'd0, 32'sd0, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_HID, 16'd0, 16'd0, 32'sd0, HID_TRANS, 16'sh7FFF, 16'sh8000, 16'sd0}, 1'b0, '0},
    '{'{REQ_HID, 16'd0, 16'd0, 32'sd0, HID_ROT, -16'sd1, 16'sd6, -16'sd6}, 1'b0, '0},
    '{'{REQ_HID, 16'd0, 16'd0, 32'sd0, HID_BTN, 16'sh80FF, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_HID, 16'd0, 16'd0, 32'sd0, HID_BTN, 16'sh7F5A, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{REQ_HID, 16'd0, 16'd0, 32'sd0, 8'd255, 16'sh1234, -16'sd9, 16'sd77}, 1'b0, '0},
    '{'{REQ_IDLE, 16'd0, 16'd0, 32'sd0, 8'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0}
  };

  six_axis_controller_event_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [15:0] deadzone_clamp(input logic [31:0] raw);
    longint v;
    longint mag;
    longint dz;
    longint fs;
    v = longint'($signed(raw));
    mag = (v < 0) ? -v : v;
    dz = longint'(dz_cfg);
    fs = longint'(fs_cfg);
    if (mag < dz) begin
      v = 0;
    end else if (v < 0) begin
      v = v + dz;
    end else if (v > 0) begin
      v = v - dz;
    end
    if (v > fs) begin
      v = fs;
    end
    if (v < -fs) begin
      v = -fs;
    end
    return v[15:0];
  endfunction

  function automatic out_t decode_request(input in_t r);
    logic [31:0] val;
    logic signed [15:0] w [3];
    int slot;
    int base;
    out_t o;
    w[0] = r.hid_word0;
    w[1] = r.hid_word1;
    w[2] = r.hid_word2;
    case (r.req_type)
      REQ_EVENT: begin
        idle_run = 0;
        case (r.ev_type)
          EV_SYNC: begin
            for (int k = 0; k < AXIS_COUNT; k++) axis_now[k] = deadzone_clamp(raw_latch[k]);
          end
          EV_KEY: begin
            slot = r.ev_code % BUTTON_COUNT_DEF;
            if (!abs_flag && slot <= 1) slot = slot + 6;
            btn_held[slot] = (r.ev_value != 0);
          end
          EV_REL: begin
            abs_flag = 1'b0;
            rel_flag = 1'b1;
            raw_latch[r.ev_code % AXIS_COUNT] = r.ev_value;
          end
          EV_ABS: begin
            abs_flag = 1'b1;
            rel_flag = 1'b0;
            slot = r.ev_code % AXIS_COUNT;
            val = r.ev_value;
            if (slot % 3 == 2) begin
              slot = slot - 1;
            end else if (slot % 3 == 1) begin
              slot = slot + 1;
              val = 32'd0 - val;
            end
            raw_latch[slot] = val;
          end
          default: ;
        endcase
      end
      REQ_HID: begin
        if (r.hid_kind == HID_TRANS || r.hid_kind == HID_ROT) begin
          base = (r.hid_kind == HID_TRANS) ? 0 : 3;
          for (int k = 0; k < 3; k++) begin
            raw_latch[base + k] = {{16{w[k][15]}}, w[k]};
            axis_now[base + k] = deadzone_clamp(raw_latch[base + k]);
          end
        end else if (r.hid_kind == HID_BTN) begin
          btn_held[13:6] = r.hid_word0[7:0];
        end
      end
      REQ_IDLE: begin
        if (idle_run < 65535) idle_run = idle_run + 1;
        if (rel_flag && idle_run >= tk_cfg) begin
          for (int k = 0; k < AXIS_COUNT; k++) begin
            raw_latch[k] = '0;
            axis_now[k] = '0;
          end
          idle_run = 0;
        end
      end
      default: ;
    endcase
    o.trans_x = axis_now[0];
    o.trans_y = axis_now[1];
    o.trans_z = axis_now[2];
    o.rot_x = axis_now[3];
    o.rot_y = axis_now[4];
    o.rot_z = axis_now[5];
    o.pressed_buttons = btn_held;
    o.absolute_device = abs_flag;
    return o;
  endfunction

  function automatic logic [31:0] raw_axis_value();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 60) begin
      v = $urandom_range(1200) - 600;
      return v;
    end else if (sel < 80) begin
      return $urandom;
    end else if (sel < 85) begin
      return 32'h80000000;
    end else if (sel < 90) begin
      return 32'h7FFFFFFF;
    end else if (sel < 94) begin
      return {24'd0, dz_cfg};
    end else if (sel < 97) begin
      return 32'd0 - {24'd0, dz_cfg};
    end
    return {24'd0, dz_cfg} - 32'd1;
  endfunction

  function automatic logic [15:0] hid_word();
    int v;
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(99) < 60) begin
      v = $urandom_range(1200) - 600;
      return v[15:0];
    end
    return a[15:0];
  endfunction

  function automatic in_t random_request(input bit idle_only);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    int pick;
    in_t r;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    d = $urandom;
    r.req_type = REQ_EVENT;
    r.ev_type = a[15:0];
    r.ev_code = a[31:16];
    r.ev_value = b;
    r.hid_kind = c[7:0];
    r.hid_word0 = c[31:16];
    r.hid_word1 = d[15:0];
    r.hid_word2 = d[31:16];
    pick = idle_only ? 99 : $urandom_range(99);
    if (pick < 35) begin
      r.ev_type = (pick < 20) ? EV_REL : EV_ABS;
      if ($urandom_range(99) < 80) r.ev_code = 16'($urandom_range(5));
      r.ev_value = raw_axis_value();
    end else if (pick < 52) begin
      r.ev_type = EV_SYNC;
    end else if (pick < 62) begin
      r.ev_type = EV_KEY;
      if ($urandom_range(99) < 75) r.ev_code = 16'($urandom_range(40));
      if ($urandom_range(99) < 70) r.ev_value = $urandom_range(1);
    end else if (pick < 72) begin
      r.req_type = REQ_HID;
      r.hid_kind = (pick < 67) ? HID_TRANS : HID_ROT;
      r.hid_word0 = hid_word();
      r.hid_word1 = hid_word();
      r.hid_word2 = hid_word();
    end else if (pick < 77) begin
      r.req_type = REQ_HID;
      r.hid_kind = HID_BTN;
    end else if (pick < 80) begin
      r.req_type = REQ_HID;
    end else if (pick < 84) begin
      r.ev_type = 16'($urandom_range(65535, 4));
    end else if (pick < 86) begin
      r.req_type = REQ_UNUSED;
    end else begin
      r.req_type = REQ_IDLE;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic send(input in_t r, input bit known, input out_t typed);
    out_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = decode_request(r);
    if (known) predicted = typed;
    owed_reports = {owed_reports, predicted};
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] dz, input logic [14:0] fs,
                              input logic [15:0] tk);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEADZONE;
    cfg_wdata <= {junk[7:0], dz};
    @(posedge clk);
    cfg_index <= CFG_FULL_SCALE;
    cfg_wdata <= {junk[8], fs};
    @(posedge clk);
    cfg_index <= CFG_IDLE_TICKS;
    cfg_wdata <= tk;
    @(posedge clk);
    cfg_we <= 1'b0;
    dz_cfg = dz;
    fs_cfg = fs;
    tk_cfg = tk;
  endtask

  task automatic run_phase(input int n);
    int pause_at;
    int k;
    int cap;
    int burst;
    bit paused;
    pause_at = $urandom_range(n - 1);
    paused = 1'b0;
    k = 0;
    cap = (tk_cfg > 58) ? 60 : tk_cfg + 2;
    while (k < n) begin
      if (!paused && k >= pause_at) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 8) begin
        burst = $urandom_range(cap, 1);
        repeat (burst) send(random_request(1'b1), 1'b0, '0);
        k = k + burst;
      end else begin
        send(random_request(1'b0), 1'b0, '0);
        k++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_reports.size() == 0) begin
        note_mismatch("result transfer with nothing outstanding");
      end else begin
        oldest_report = owed_reports.pop_front();
        check_field("trans_x", 32'(out_data.trans_x), 32'(oldest_report.trans_x));
        check_field("trans_y", 32'(out_data.trans_y), 32'(oldest_report.trans_y));
        check_field("trans_z", 32'(out_data.trans_z), 32'(oldest_report.trans_z));
        check_field("rot_x", 32'(out_data.rot_x), 32'(oldest_report.rot_x));
        check_field("rot_y", 32'(out_data.rot_y), 32'(oldest_report.rot_y));
        check_field("rot_z", 32'(out_data.rot_z), 32'(oldest_report.rot_z));
        check_field("pressed_buttons", out_data.pressed_buttons,
                    oldest_report.pressed_buttons);
        check_field("absolute_device", 32'(out_data.absolute_device),
                    32'(oldest_report.absolute_device));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("six_axis_controller_event_decoder_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < AXIS_COUNT; k++) begin
      raw_latch[k] = '0;
      axis_now[k] = '0;
    end
    btn_held = '0;
    abs_flag = 1'b0;
    rel_flag = 1'b0;
    idle_run = 0;
    dz_cfg = DEADZONE_RST;
    fs_cfg = FULL_SCALE_RST;
    tk_cfg = IDLE_TICKS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) send(plan[i].req, plan[i].known, plan[i].want);
    run_phase(200);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_config(8'(ph_dz[p]), 15'(ph_fs[p]), 16'(ph_tk[p]));
      idle_pct = ph_idle[p];
      stall_pct = ph_stall[p];
      run_phase(190);
    end

    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && owed_reports.size() == 0) begin
      $display("six_axis_controller_event_decoder_unit_tb: done, clean");
    end else begin
      $display("six_axis_controller_event_decoder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
